// ----- rtl/rc3_pkg.sv -----
package rc3_pkg;

  // One input transfer: a raster pixel or a drain item.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       filler;
  } pixel_in_t;

  // One output transfer.
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_pixel;
  } pixel_out_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_TAPS_TOP     = 3'd2,
    REG_TAPS_MIDDLE  = 3'd3,
    REG_TAPS_BOTTOM  = 3'd4
  } cfg_reg_e;

  localparam int PIX_W        = 24;
  localparam int TAP_W        = 16;
  localparam int NUM_TAPS     = 9;
  localparam int CFG_W        = 48;
  localparam int DIM_W        = 12;
  localparam int HEIGHT_LIMIT = 2048;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  // Work handed from the window stage to the arithmetic stage.
  // Window entry k sits at kernel row k/3, column k%3; red is in the low byte.
  typedef struct packed {
    logic [NUM_TAPS-1:0][PIX_W-1:0] win;
    logic                           interior;
    logic                           last;
  } job_t;

endpackage

// ----- rtl/rc3_fifo.sv -----
module rc3_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  rc3_pkg::job_t                   push_data_i,
  input  logic                            pop_i,
  output rc3_pkg::job_t                   pop_data_o,
  output logic                            empty_o,
  output logic [rc3_pkg::FIFO_CNT_W-1:0]  count_o
);

  localparam int PW = $clog2(rc3_pkg::FIFO_DEPTH);

  rc3_pkg::job_t                  mem_q [rc3_pkg::FIFO_DEPTH];
  logic [PW-1:0]                  wr_ptr_q, rd_ptr_q;
  logic [rc3_pkg::FIFO_CNT_W-1:0] count_q, count_d;

  assign empty_o    = (count_q == '0);
  assign count_o    = count_q;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && !pop_i && (count_q == rc3_pkg::FIFO_CNT_W'(rc3_pkg::FIFO_DEPTH))))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("queue read while empty");
`endif

endmodule

// ----- rtl/rc3_front.sv -----
module rc3_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rc3_pkg::pixel_in_t              in_data_i,
  input  logic [rc3_pkg::DIM_W-1:0]       width_i,
  input  logic [rc3_pkg::DIM_W-1:0]       height_i,
  input  logic [rc3_pkg::FIFO_CNT_W-1:0]  fifo_count_i,
  output logic                            push_o,
  output rc3_pkg::job_t                   push_data_o
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int HW = rc3_pkg::DIM_W;
  localparam int PW = rc3_pkg::PIX_W;

  logic            in_acc;
  logic [WW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;
  logic [WW-1:0]   col_q, col_d, c0, c1;
  logic [HW-1:0]   row_q, row_d, r0;
  logic            last, produce, interior;
  logic [WW-1:0]   ox;
  logic [HW-1:0]   oy;

  // Stage two: line store data arrives, window shifts.
  logic            s2_valid_q, s2_last_q, s2_produce_q, s2_interior_q;
  logic [AW-1:0]   s2_addr_q;
  logic [PW-1:0]   s2_pix_q;
  logic [2*PW-1:0] mem_q [MAX_WIDTH];
  logic [2*PW-1:0] rd_q, byp_data_q, merged, wr_data;
  logic            byp_q;
  logic [rc3_pkg::NUM_TAPS-1:0][PW-1:0] win_q, win_d;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = ({1'b0, fifo_count_i} + {{rc3_pkg::FIFO_CNT_W{1'b0}}, s2_valid_q})
                      >= (rc3_pkg::FIFO_CNT_W + 1)'(rc3_pkg::FIFO_DEPTH);

  always_comb begin
    if (width_i == '0) begin
      w_eff = WW'(1);
    end else if (int'(width_i) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_i);
    end
    if (height_i == '0) begin
      h_eff = HW'(1);
    end else if (int'(height_i) > rc3_pkg::HEIGHT_LIMIT) begin
      h_eff = HW'(rc3_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = height_i;
    end
  end

  always_comb begin
    c0 = col_q;
    r0 = row_q;
    if (col_q >= w_eff) begin
      c0 = '0;
      r0 = row_q + 1'b1;
    end
    last = {1'b0, r0} >= ({1'b0, h_eff} + 1'b1);
    c1   = c0 + 1'b1;
    if (last) begin
      col_d = '0;
      row_d = '0;
    end else if (c1 >= w_eff) begin
      col_d = '0;
      row_d = r0 + 1'b1;
    end else begin
      col_d = c1;
      row_d = r0;
    end
    produce = !((r0 == '0) || ((r0 == HW'(1)) && (c0 == '0)));
    if (c0 == '0) begin
      ox = w_eff - 1'b1;
      oy = r0 - HW'(2);
    end else begin
      ox = c0 - 1'b1;
      oy = r0 - 1'b1;
    end
    interior = (w_eff >= WW'(3)) && (h_eff >= HW'(3)) && (ox != '0) && (oy != '0)
               && (({1'b0, ox} + (WW + 1)'(2)) <= {1'b0, w_eff})
               && (({1'b0, oy} + (HW + 1)'(2)) <= {1'b0, h_eff});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= in_acc;
      if (in_acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s2_addr_q     <= c0[AW-1:0];
      s2_pix_q      <= in_data_i.filler ? '0
                       : {in_data_i.blue, in_data_i.green, in_data_i.red};
      s2_last_q     <= last;
      s2_produce_q  <= produce;
      s2_interior_q <= interior;
      rd_q          <= mem_q[c0[AW-1:0]];
      byp_q         <= s2_valid_q && (s2_addr_q == c0[AW-1:0]);
      byp_data_q    <= wr_data;
    end
  end

  // Upper half holds the older line, lower half the newer one.
  assign merged  = byp_q ? byp_data_q : rd_q;
  assign wr_data = {merged[PW-1:0], s2_pix_q};

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) mem_q[s2_addr_q] <= wr_data;
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[3*r]     = win_q[3*r + 1];
      win_d[3*r + 1] = win_q[3*r + 2];
    end
    win_d[2] = merged[2*PW-1:PW];
    win_d[5] = merged[PW-1:0];
    win_d[8] = s2_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s2_valid_q) begin
      win_q <= win_d;
    end
  end

  assign push_o               = s2_valid_q && s2_produce_q;
  assign push_data_o.win      = win_d;
  assign push_data_o.interior = s2_interior_q;
  assign push_data_o.last     = s2_last_q;

`ifndef SYNTHESIS
  a_frame_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last) |=> (col_q == '0) && (row_q == '0))
    else $error("counters not cleared at frame end");
`endif

endmodule

// ----- rtl/rc3_back.sv -----
module rc3_back #(
  parameter int TAP_FRACTION_BITS = 8
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic [rc3_pkg::NUM_TAPS-1:0][rc3_pkg::TAP_W-1:0]  taps_i,
  input  logic                                              job_valid_i,
  input  rc3_pkg::job_t                                     job_i,
  output logic                                              pop_o,
  output logic                                              out_valid_o,
  input  logic                                              out_stall_i,
  output rc3_pkg::pixel_out_t                               out_data_o
);

  localparam int PRW = 25;
  localparam int RSW = 27;
  localparam int TSW = 29;
  localparam logic [TSW-1:0] RND = TSW'((64'd1 << TAP_FRACTION_BITS) >> 1);

  logic advance;
  logic v1_q, v2_q, vo_q;
  logic int1_q, int2_q, last1_q, last2_q;
  logic [rc3_pkg::PIX_W-1:0] ctr1_q, ctr2_q;
  logic [2:0][rc3_pkg::NUM_TAPS-1:0][PRW-1:0] prod_d, prod_q;
  logic [2:0][2:0][RSW-1:0] rs_d, rs_q;
  logic [2:0][7:0] res;
  logic signed [TSW-1:0] tot;
  logic signed [TSW-1:0] q;
  rc3_pkg::pixel_out_t out_q;

  assign advance     = !vo_q || !out_stall_i;
  assign pop_o       = advance && job_valid_i;
  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < rc3_pkg::NUM_TAPS; k++) begin
        prod_d[ch][k] = PRW'($signed({1'b0, job_i.win[k][8*ch +: 8]}) * $signed(taps_i[k]));
      end
      for (int r = 0; r < 3; r++) begin
        rs_d[ch][r] = RSW'($signed(prod_q[ch][3*r])) + RSW'($signed(prod_q[ch][3*r + 1]))
                      + RSW'($signed(prod_q[ch][3*r + 2]));
      end
    end
  end

  always_comb begin
    res = '0;
    tot = '0;
    q   = '0;
    for (int ch = 0; ch < 3; ch++) begin
      tot = TSW'($signed(rs_q[ch][0])) + TSW'($signed(rs_q[ch][1]))
            + TSW'($signed(rs_q[ch][2])) + $signed(RND);
      q   = tot >>> TAP_FRACTION_BITS;
      if (!int2_q) begin
        res[ch] = ctr2_q[8*ch +: 8];
      end else if (tot < 0) begin
        res[ch] = 8'd0;
      end else if (q > TSW'(255)) begin
        res[ch] = 8'd255;
      end else begin
        res[ch] = q[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (advance) begin
      v1_q <= job_valid_i;
      v2_q <= v1_q;
      vo_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      prod_q  <= prod_d;
      int1_q  <= job_i.interior;
      last1_q <= job_i.last;
      ctr1_q  <= job_i.win[4];
      rs_q    <= rs_d;
      int2_q  <= int1_q;
      last2_q <= last1_q;
      ctr2_q  <= ctr1_q;
      out_q   <= '{out_red: res[0], out_green: res[1], out_blue: res[2],
                   last_pixel: last2_q};
    end
  end

`ifndef SYNTHESIS
  a_result_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && advance) |=> vo_q)
    else $error("finished result lost before output register");
`endif

endmodule

// ----- rtl/rgb_convolution_3x3.sv -----
// Streaming 3x3 convolution on RGB pixels in raster order: one programmable kernel of
// nine signed fixed-point taps (TAP_FRACTION_BITS fraction bits) is applied to red,
// green and blue alike, each sum rounded half up and clamped to 0..255. Border pixels,
// and every pixel of a frame narrower or shorter than three, pass through unchanged.
// The block takes one pixel per clock and returns one result per clock while out_stall_i is low.
// An output lags its input by one row plus one pixel, so after a frame of W*H pixels
// send W+1 filler transfers to drain it; the last result carries last_pixel. Two line
// buffers of MAX_WIDTH entries live in one dual-half memory read once per pixel, so
// the rate is bounded by that single read port at one pixel per cycle. A window stage
// feeds a four-entry queue ahead of a three-stage multiply and sum pipeline. Write
// configuration only while the block is idle.
module rgb_convolution_3x3 #(
  parameter int MAX_WIDTH         = 2048,
  parameter int TAP_FRACTION_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  rc3_pkg::pixel_in_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output rc3_pkg::pixel_out_t         out_data_o,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_idx_i,
  input  logic [rc3_pkg::CFG_W-1:0]   cfg_data_i
);

  logic [rc3_pkg::DIM_W-1:0] width_q, height_q;
  logic [rc3_pkg::CFG_W-1:0] taps_top_q, taps_mid_q, taps_bot_q;
  logic [rc3_pkg::NUM_TAPS-1:0][rc3_pkg::TAP_W-1:0] taps;

  logic                           push, pop, empty;
  rc3_pkg::job_t                  push_data, pop_data;
  logic [rc3_pkg::FIFO_CNT_W-1:0] fifo_count;

  // Configuration registers; a write to an unused index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= rc3_pkg::DIM_W'(640);
      height_q   <= rc3_pkg::DIM_W'(480);
      taps_top_q <= '0;
      taps_mid_q <= rc3_pkg::CFG_W'(48'h00_0001_000000);
      taps_bot_q <= '0;
    end else if (cfg_we_i) begin
      case (rc3_pkg::cfg_reg_e'(cfg_idx_i))
        rc3_pkg::REG_IMAGE_WIDTH:  width_q    <= cfg_data_i[rc3_pkg::DIM_W-1:0];
        rc3_pkg::REG_IMAGE_HEIGHT: height_q   <= cfg_data_i[rc3_pkg::DIM_W-1:0];
        rc3_pkg::REG_TAPS_TOP:     taps_top_q <= cfg_data_i;
        rc3_pkg::REG_TAPS_MIDDLE:  taps_mid_q <= cfg_data_i;
        rc3_pkg::REG_TAPS_BOTTOM:  taps_bot_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Tap 0 is the low field of the top row register.
  assign taps = {taps_bot_q, taps_mid_q, taps_top_q};

  // The front end tracks position, keeps the line buffers and the window, and
  // queues only the transfers that produce a result.
  rc3_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .width_i      (width_q),
    .height_i     (height_q),
    .fifo_count_i (fifo_count),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  rc3_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty),
    .count_o     (fifo_count)
  );

  // The back end multiplies, sums, rounds and clamps, stalling on the output only.
  rc3_back #(
    .TAP_FRACTION_BITS (TAP_FRACTION_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .taps_i      (taps),
    .job_valid_i (!empty),
    .job_i       (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_stall_when_queue_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_count == rc3_pkg::FIFO_CNT_W'(rc3_pkg::FIFO_DEPTH)) |-> in_stall_o)
    else $error("input taken with no queue space");
`endif

endmodule
